>>> hw/rtl/rmsd_pkg.sv
package rmsd_pkg;

   // Pair count limit; pairs beyond it are dropped and flagged
   localparam int unsigned MAX_ITEMS = 4096;

   // Field and datapath widths
   localparam int unsigned IN_W    = 24;   // signed Q11.12 coordinate
   localparam int unsigned MAG_W   = 24;   // |first - second| never exceeds 2^24 - 1
   localparam int unsigned SQ_W    = 2 * MAG_W;
   localparam int unsigned SUM_W   = 62;
   localparam int unsigned CNT_W   = 13;
   localparam int unsigned RMS_W   = 25;
   localparam int unsigned ROOT_W  = 24;   // root of a mean below 2^48
   localparam int unsigned MEAN_W  = 2 * ROOT_W;
   localparam int unsigned REM_W   = ROOT_W + 1;
   localparam int unsigned ALU_W   = ROOT_W + 2;
   localparam int unsigned STEP_W  = 6;

   // Iteration counts of the shared compare/subtract unit
   localparam int unsigned DIV_STEPS  = SUM_W;
   localparam int unsigned SQRT_STEPS = ROOT_W;

   typedef logic signed [IN_W-1:0] coord_type;
   typedef logic [CNT_W-1:0]        count_type;
   typedef logic [RMS_W-1:0]        rms_type;

endpackage

>>> hw/rtl/rmsd_if.sv
interface rmsd_req_if;
   logic                valid;
   logic                ready;
   rmsd_pkg::coord_type first_value;
   rmsd_pkg::coord_type second_value;
   logic                last_item;

   modport source (output valid, first_value, second_value, last_item, input ready);
   modport sink   (input valid, first_value, second_value, last_item, output ready);
endinterface

interface rmsd_rsp_if;
   logic                valid;
   logic                ready;
   rmsd_pkg::rms_type   rms_value;
   rmsd_pkg::count_type pair_count;
   logic                saturated;

   modport source (output valid, rms_value, pair_count, saturated, input ready);
   modport sink   (input valid, rms_value, pair_count, saturated, output ready);
endinterface

>>> hw/rtl/rms_deviation_accumulator.sv
// RMS deviation of two vectors streamed one element pair per item.
// req_bus (valid/ready) carries first_value, second_value (signed Q11.12) and
// last_item. Each pair's squared difference is added to a running sum; the
// item with last_item set closes the vector and yields one item on rsp_bus:
// rms_value = floor(sqrt(sum / count)) in Q13.12, pair_count and saturated.
// Pairs arriving when MAX_ITEMS pairs are already held are dropped and set
// saturated. Sum, count and flag clear after the last item.
// An ordinary item is accepted in ST_IDLE, squared in ST_MUL and added in ST_ACC;
// ready is low in ST_MUL and ST_ACC, so the next item waits for the accumulate.
// The last item is squared and added the same way. The mean is then formed by
// 62 restoring-division steps and its root by 24 square-root steps on one
// shared 26-bit compare/subtract unit. ST_HOLD then loads the result into the
// output register once that register is free.
// The output register lets new items be accumulated while a result waits;
// if a second result is done before the first is taken, the block holds it
// and keeps ready low until the receiver takes the first.
// Reset (synchronous, active high) clears the sum, count, flag, the sequencer
// and the output valid.
module rms_deviation_accumulator (
   input logic        clock,
   input logic        reset,
   rmsd_req_if.sink   req_bus,
   rmsd_rsp_if.source rsp_bus
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_ACC,
      ST_DIV,
      ST_SQRT,
      ST_HOLD
   } state_type;

   localparam int unsigned MAG_W  = rmsd_pkg::MAG_W;
   localparam int unsigned SQ_W   = rmsd_pkg::SQ_W;
   localparam int unsigned SUM_W  = rmsd_pkg::SUM_W;
   localparam int unsigned CNT_W  = rmsd_pkg::CNT_W;
   localparam int unsigned ROOT_W = rmsd_pkg::ROOT_W;
   localparam int unsigned MEAN_W = rmsd_pkg::MEAN_W;
   localparam int unsigned REM_W  = rmsd_pkg::REM_W;
   localparam int unsigned ALU_W  = rmsd_pkg::ALU_W;
   localparam int unsigned STEP_W = rmsd_pkg::STEP_W;

   state_type           state_ff, state_in;
   logic [MAG_W-1:0]    mag_ff, mag_in;
   logic                last_ff, last_in;
   logic [SQ_W-1:0]     prod_ff, prod_in;
   logic [SUM_W-1:0]    sum_ff, sum_in;
   logic [CNT_W-1:0]    items_ff, items_in;
   logic                over_ff, over_in;
   logic [SUM_W-1:0]    work_ff, work_in;
   logic [REM_W-1:0]    rem_ff, rem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [CNT_W-1:0]    divisor_ff, divisor_in;
   logic                flag_ff, flag_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic                rsp_valid_ff, rsp_valid_in;
   rmsd_pkg::rms_type   rms_out_ff, rms_out_in;
   rmsd_pkg::count_type count_out_ff, count_out_in;
   logic                sat_out_ff, sat_out_in;

   logic                accept;
   logic                out_free;
   logic [MAG_W:0]      diff_full;
   logic [MAG_W:0]      abs_full;
   logic                count_full;
   logic [SUM_W-1:0]    sum_next;
   logic [CNT_W-1:0]    items_next;
   logic                over_next;
   logic [CNT_W:0]      div_shift;
   logic [ALU_W-1:0]    alu_a;
   logic [ALU_W-1:0]    alu_b;
   logic [ALU_W:0]      alu_diff;
   logic                alu_ge;

   assign accept        = req_bus.valid && (state_ff == ST_IDLE);
   assign req_bus.ready = (state_ff == ST_IDLE);
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.rms_value  = rms_out_ff;
   assign rsp_bus.pair_count = count_out_ff;
   assign rsp_bus.saturated  = sat_out_ff;

   // Magnitude of the coordinate difference, taken straight from the input
   assign diff_full = {req_bus.first_value[MAG_W-1], req_bus.first_value}
                    - {req_bus.second_value[MAG_W-1], req_bus.second_value};
   assign abs_full  = diff_full[MAG_W] ? (~diff_full + 1'b1) : diff_full;

   // Accumulate unless the count is full
   assign count_full = (items_ff == CNT_W'(rmsd_pkg::MAX_ITEMS));
   assign sum_next   = count_full ? sum_ff : (sum_ff + SUM_W'(prod_ff));
   assign items_next = count_full ? items_ff : (items_ff + 1'b1);
   assign over_next  = over_ff | count_full;

   // Shared compare/subtract unit: division step or square-root step
   assign div_shift = {rem_ff[CNT_W-1:0], work_ff[SUM_W-1]};

   always_comb begin
      if (state_ff == ST_SQRT) begin
         alu_a = {rem_ff[ALU_W-3:0], work_ff[MEAN_W-1 -: 2]};
         alu_b = ALU_W'({root_ff[ROOT_W-2:0], 2'b01});
      end else begin
         alu_a = ALU_W'(div_shift);
         alu_b = ALU_W'(divisor_ff);
      end
   end

   assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
   assign alu_ge   = !alu_diff[ALU_W];

   // Sequencer and datapath next values
   always_comb begin
      state_in     = state_ff;
      mag_in       = mag_ff;
      last_in      = last_ff;
      prod_in      = prod_ff;
      sum_in       = sum_ff;
      items_in     = items_ff;
      over_in      = over_ff;
      work_in      = work_ff;
      rem_in       = rem_ff;
      root_in      = root_ff;
      divisor_in   = divisor_ff;
      flag_in      = flag_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_bus.ready;
      rms_out_in   = rms_out_ff;
      count_out_in = count_out_ff;
      sat_out_in   = sat_out_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               mag_in   = abs_full[MAG_W-1:0];
               last_in  = req_bus.last_item;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            prod_in  = mag_ff * mag_ff;
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (last_ff) begin
               // hand the totals to the divider and clear for the next vector
               work_in    = sum_next;
               divisor_in = items_next;
               flag_in    = over_next;
               sum_in     = '0;
               items_in   = '0;
               over_in    = 1'b0;
               rem_in     = '0;
               step_in    = '0;
               state_in   = ST_DIV;
            end else begin
               sum_in   = sum_next;
               items_in = items_next;
               over_in  = over_next;
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            // restoring division, one quotient bit per cycle
            rem_in  = REM_W'(alu_ge ? alu_diff[CNT_W-1:0] : div_shift[CNT_W-1:0]);
            work_in = {work_ff[SUM_W-2:0], alu_ge};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(rmsd_pkg::DIV_STEPS - 1)) begin
               rem_in   = '0;
               root_in  = '0;
               step_in  = '0;
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            // digit-by-digit square root, two mean bits per cycle
            rem_in  = alu_ge ? alu_diff[REM_W-1:0] : alu_a[REM_W-1:0];
            root_in = {root_ff[ROOT_W-2:0], alu_ge};
            work_in = {work_ff[SUM_W-3:0], 2'b00};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(rmsd_pkg::SQRT_STEPS - 1)) begin
               state_in = ST_HOLD;
            end
         end
         ST_HOLD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rms_out_in   = rmsd_pkg::RMS_W'(root_ff);
               count_out_in = divisor_ff;
               sat_out_in   = flag_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state with reset
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sum_ff       <= '0;
         items_ff     <= '0;
         over_ff      <= 1'b0;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         items_ff     <= items_in;
         over_ff      <= over_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      mag_ff       <= mag_in;
      last_ff      <= last_in;
      prod_ff      <= prod_in;
      work_ff      <= work_in;
      rem_ff       <= rem_in;
      root_ff      <= root_in;
      divisor_ff   <= divisor_in;
      flag_ff      <= flag_in;
      rms_out_ff   <= rms_out_in;
      count_out_ff <= count_out_in;
      sat_out_ff   <= sat_out_in;
   end

endmodule

>>> tb/rms_deviation_accumulator_tb.sv
module rms_deviation_accumulator_tb;

   localparam int unsigned CYCLE_LIMIT  = 1_000_000;
   localparam int unsigned RANDOM_PAIRS = 1800;
   localparam int unsigned DRAIN_CYCLES = 200;
   localparam int unsigned IDLE_PCT     = 27;
   localparam int unsigned PLAN_ROWS    = 20;
   localparam int unsigned IN_W         = rmsd_pkg::IN_W;
   localparam int unsigned SUM_W        = rmsd_pkg::SUM_W;
   localparam int unsigned RMS_W        = rmsd_pkg::RMS_W;

   localparam rmsd_pkg::coord_type COORD_MAX = 24'sh7FFFFF;
   localparam rmsd_pkg::coord_type COORD_MIN = 24'sh800000;
   localparam rmsd_pkg::rms_type   RMS_TOP   = 25'd16777215;

   typedef struct packed {
      rmsd_pkg::rms_type   rms;
      rmsd_pkg::count_type count;
      logic                sat;
   } rmsd_result_type;

   typedef struct {
      rmsd_pkg::coord_type first;
      rmsd_pkg::coord_type second;
      logic                last;
      int unsigned         reps;
      bit                  typed;
      rmsd_result_type     want;
   } plan_row_type;

   logic clock;
   logic reset;
   bit   steady;
   int unsigned cycles;
   int unsigned mismatches;

   // predictor state
   logic [SUM_W-1:0]    held_sum;
   rmsd_pkg::count_type held_count;
   logic                held_overflow;

   rmsd_result_type pending_rms [$];
   plan_row_type    plan [0:PLAN_ROWS-1];

   rmsd_req_if req_bus ();
   rmsd_rsp_if rsp_bus ();

   rms_deviation_accumulator dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // floor square root, one result bit per pass; the mean stays below 2^60
   function automatic logic [31:0] floor_sqrt(input logic [63:0] n);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      for (int b = 30; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= n) root = trial;
      end
      return root[31:0];
   endfunction

   // Fold one accepted pair into the running sum; return 1 when it closes a vector
   function automatic bit fold_pair(input rmsd_pkg::coord_type a,
                                    input rmsd_pkg::coord_type b, input logic last,
                                    output rmsd_result_type r);
      logic signed [IN_W:0] diff;
      logic [2*IN_W-1:0]    mag;
      logic [2*IN_W-1:0]    sq;
      logic [63:0]          mean;
      r = '0;
      diff = $signed({a[IN_W-1], a}) - $signed({b[IN_W-1], b});
      mag  = (diff < 0) ? (2*IN_W)'(-diff) : (2*IN_W)'(diff);
      sq   = mag * mag;
      // drop pairs once the count is full
      if (held_count < rmsd_pkg::MAX_ITEMS) begin
         held_sum   = held_sum + SUM_W'(sq);
         held_count = held_count + 1'b1;
      end else begin
         held_overflow = 1'b1;
      end
      if (!last) return 1'b0;
      mean    = 64'(held_sum) / 64'(held_count);
      r.rms   = RMS_W'(floor_sqrt(mean));
      r.count = held_count;
      r.sat   = held_overflow;
      held_sum      = '0;
      held_count    = '0;
      held_overflow = 1'b0;
      return 1'b1;
   endfunction

   function automatic rmsd_pkg::coord_type corner_value(input int unsigned k);
      case (k % 5)
         0: return COORD_MAX;
         1: return COORD_MIN;
         2: return '0;
         3: return -24'sd1;
         default: return 24'sd1;
      endcase
   endfunction

   // Offer one item, hold it until accepted, then update the prediction
   task automatic push_pair(input rmsd_pkg::coord_type a, input rmsd_pkg::coord_type b,
                            input logic last, input bit typed_on,
                            input rmsd_result_type typed_val);
      rmsd_result_type r;
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.first_value  <= a;
      req_bus.second_value <= b;
      req_bus.last_item    <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      if (fold_pair(a, b, last, r)) pending_rms.push_back(typed_on ? typed_val : r);
      @(negedge clock);
   endtask

   // Throttle the result side
   always @(negedge clock) begin
      rsp_bus.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
   end

   // Check each accepted result against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_rms.size() == 0) begin
            $display("%0t: unexpected result rms=%0d count=%0d sat=%0b", $time,
                     rsp_bus.rms_value, rsp_bus.pair_count, rsp_bus.saturated);
            mismatches++;
         end else begin
            rmsd_result_type want;
            want = pending_rms.pop_front();
            if (rsp_bus.rms_value !== want.rms || rsp_bus.pair_count !== want.count ||
                rsp_bus.saturated !== want.sat) begin
               $display("%0t: mismatch expected rms=%0d count=%0d sat=%0b, %s",
                        $time, want.rms, want.count, want.sat, "got");
               $display("%0t:    got rms=%0d count=%0d sat=%0b",
                        $time, rsp_bus.rms_value, rsp_bus.pair_count, rsp_bus.saturated);
               mismatches++;
            end
         end
      end
   end

   // Stop a hung run
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d results outstanding", $time, pending_rms.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      rmsd_pkg::coord_type a;
      rmsd_pkg::coord_type b;
      int unsigned         len;
      int unsigned         sent;
      int unsigned         pick;
      rmsd_result_type     none;

      none          = '0;
      steady        = 1'b0;
      held_sum      = '0;
      held_count    = '0;
      held_overflow = 1'b0;
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.first_value  = '0;
      req_bus.second_value = '0;
      req_bus.last_item    = 1'b0;

      // directed rows: single pairs at the extremes, short vectors, a full count,
      // dropped pairs (including a dropped closing pair) and a clear afterward
      plan = '{
         '{24'sd0,      24'sd0,      1'b1, 1,    1'b1, '{25'd0,    13'd1,    1'b0}},
         '{COORD_MAX,   COORD_MIN,   1'b1, 1,    1'b1, '{RMS_TOP,  13'd1,    1'b0}},
         '{COORD_MIN,   COORD_MAX,   1'b1, 1,    1'b1, '{RMS_TOP,  13'd1,    1'b0}},
         '{COORD_MIN,   COORD_MIN,   1'b1, 1,    1'b1, '{25'd0,    13'd1,    1'b0}},
         '{COORD_MAX,   COORD_MAX,   1'b1, 1,    1'b1, '{25'd0,    13'd1,    1'b0}},
         '{24'sd4096,   24'sd0,      1'b1, 1,    1'b1, '{25'd4096, 13'd1,    1'b0}},
         '{-24'sd1,     24'sd0,      1'b1, 1,    1'b1, '{25'd1,    13'd1,    1'b0}},
         '{24'sd3,      24'sd0,      1'b0, 1,    1'b0, '0},
         '{24'sd4,      24'sd0,      1'b1, 1,    1'b0, '0},
         '{24'sd5,      -24'sd5,     1'b0, 1,    1'b0, '0},
         '{-24'sd7,     24'sd2,      1'b0, 1,    1'b0, '0},
         '{24'sd123456, -24'sd654321, 1'b1, 1,   1'b0, '0},
         '{COORD_MAX,   COORD_MIN,   1'b1, 4096, 1'b1, '{RMS_TOP,  13'd4096, 1'b0}},
         '{COORD_MAX,   COORD_MIN,   1'b1, 4097, 1'b1, '{RMS_TOP,  13'd4096, 1'b1}},
         '{24'sd1,      24'sd0,      1'b0, 4097, 1'b0, '0},
         '{24'sd0,      24'sd0,      1'b1, 1,    1'b1, '{25'd1,    13'd4096, 1'b1}},
         '{24'sd2,      24'sd0,      1'b1, 1,    1'b1, '{25'd2,    13'd1,    1'b0}},
         '{24'sd1,      24'sd0,      1'b0, 1,    1'b0, '0},
         '{24'sd0,      24'sd0,      1'b0, 1,    1'b0, '0},
         '{24'sd0,      24'sd0,      1'b1, 1,    1'b0, '0}
      };

      repeat (8) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // walk the directed table; last only on the final repeat of a row
      for (int i = 0; i < PLAN_ROWS; i++) begin
         for (int unsigned k = 1; k <= plan[i].reps; k++) begin
            push_pair(plan[i].first, plan[i].second, plan[i].last && (k == plan[i].reps),
                      plan[i].typed && (k == plan[i].reps), plan[i].want);
         end
      end

      // random vectors, mostly short
      sent = 0;
      while (sent < RANDOM_PAIRS) begin
         pick = $urandom_range(99);
         if (pick < 70)      len = $urandom_range(6, 1);
         else if (pick < 95) len = $urandom_range(40, 7);
         else                len = $urandom_range(200, 41);
         for (int unsigned k = 1; k <= len; k++) begin
            steady = (sent >= 700 && sent < 1000);
            pick = $urandom_range(9);
            a = rmsd_pkg::coord_type'($urandom);
            b = rmsd_pkg::coord_type'($urandom);
            if (pick >= 5 && pick < 7) begin
               a = corner_value($urandom);
               b = corner_value($urandom);
            end else if (pick >= 7) begin
               b = a + rmsd_pkg::coord_type'($urandom_range(128) - 64);
            end
            push_pair(a, b, k == len, 1'b0, none);
            sent++;
         end
      end
      steady = 1'b0;
      req_bus.valid     <= 1'b0;
      req_bus.last_item <= 1'b0;

      // drain outstanding results, then allow stray ones to show up
      while (pending_rms.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
